FILE: design/rrcd_pkg.sv
// shared types and constants for the remote code decoder with learning store
// no dependencies
package rrcd_pkg;

   // pulse width limits in microseconds, all bounds exclusive
   localparam logic [15:0] PREAMBLE_MAX_US  = 16'd12350;
   localparam logic [15:0] PREAMBLE_MIN_US  = 16'd8000;
   localparam logic [15:0] LONG_LOW_MAX_US  = 16'd1200;
   localparam logic [15:0] LONG_LOW_MIN_US  = 16'd750;
   localparam logic [15:0] SHORT_HI_MAX_US  = 16'd600;
   localparam logic [15:0] SHORT_HI_MIN_US  = 16'd250;
   localparam logic [15:0] SHORT_LOW_MAX_US = 16'd550;
   localparam logic [15:0] SHORT_LOW_MIN_US = 16'd100;
   localparam logic [15:0] LONG_HI_MAX_US   = 16'd1350;
   localparam logic [15:0] LONG_HI_MIN_US   = 16'd800;

   localparam int FRAME_BITS = 24;
   localparam int WORD_BITS  = 10;
   localparam int CODE_BITS  = 2 * WORD_BITS;

   // operating modes
   localparam logic [1:0] MODE_MATCH  = 2'd0;
   localparam logic [1:0] MODE_LEARN  = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   // frame decoder outcome for one edge
   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] code_high;
      logic [WORD_BITS-1:0] code_low;
      logic [3:0]           command_bits;
   } frame_type;

   // search probe walking along the slot cells
   typedef struct packed {
      logic                 live;
      logic [CODE_BITS-1:0] code;
      logic [1:0]           mode;
      logic                 hit;
      logic                 free;
   } probe_type;

   // one result item
   typedef struct packed {
      logic                 frame_done;
      logic [WORD_BITS-1:0] code_high;
      logic [WORD_BITS-1:0] code_low;
      logic [3:0]           command_bits;
      logic                 matched;
      logic                 match_slot;
      logic                 learned;
      logic                 already_known;
      logic                 learn_refused;
      logic                 deleted;
   } rsp_data_type;

endpackage

FILE: design/rrcd_if.sv
// valid/ready channel interfaces for edge items and result items
// no dependencies
interface rrcd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] duration_us;
   logic        line_level;
   logic [1:0]  mode;

   modport source (output valid, duration_us, line_level, mode, input ready);
   modport sink   (input valid, duration_us, line_level, mode, output ready);
endinterface

interface rrcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic [9:0] code_high;
   logic [9:0] code_low;
   logic [3:0] command_bits;
   logic       matched;
   logic       match_slot;
   logic       learned;
   logic       already_known;
   logic       learn_refused;
   logic       deleted;

   modport source (output valid, frame_done, code_high, code_low, command_bits, matched,
                   match_slot, learned, already_known, learn_refused, deleted,
                   input ready);
   modport sink   (input valid, frame_done, code_high, code_low, command_bits, matched,
                   match_slot, learned, already_known, learn_refused, deleted,
                   output ready);
endinterface

FILE: design/rrcd_frame_decoder.sv
// pulse width frame decoder: preamble search and 24-bit data collection
// depends on rrcd_pkg
module rrcd_frame_decoder
   import rrcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [15:0] duration_us,
   input  logic        line_level,
   output frame_type   frame
);

   localparam logic [1:0] PH_PREAMBLE = 2'd0;
   localparam logic [1:0] PH_LOW      = 2'd1;
   localparam logic [1:0] PH_ONE_HIGH = 2'd2;
   localparam logic [1:0] PH_ZERO_HI  = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic [4:0]            count_ff, count_in;
   logic [FRAME_BITS-1:0] bits_ff, bits_in;
   logic                  take, bit_value, done;

   // interval classification and phase sequencing
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      bits_in   = bits_ff;
      take      = 1'b0;
      bit_value = 1'b0;
      done      = 1'b0;
      if (phase_ff == PH_PREAMBLE) begin
         if (duration_us > PREAMBLE_MIN_US && duration_us < PREAMBLE_MAX_US && line_level) begin
            phase_in = PH_LOW;
            count_in = 5'd0;
            bits_in  = '0;
         end else begin
            phase_in = PH_PREAMBLE;
            count_in = 5'd0;
         end
      end else if (phase_ff == PH_LOW && duration_us > LONG_LOW_MIN_US &&
                   duration_us < LONG_LOW_MAX_US && !line_level) begin
         phase_in = PH_ONE_HIGH;
      end else if (phase_ff == PH_ONE_HIGH && duration_us > SHORT_HI_MIN_US &&
                   duration_us < SHORT_HI_MAX_US && line_level) begin
         take      = 1'b1;
         bit_value = 1'b1;
      end else if (phase_ff == PH_LOW && duration_us > SHORT_LOW_MIN_US &&
                   duration_us < SHORT_LOW_MAX_US && !line_level) begin
         phase_in = PH_ZERO_HI;
      end else if (phase_ff == PH_ZERO_HI && duration_us > LONG_HI_MIN_US &&
                   duration_us < LONG_HI_MAX_US && line_level) begin
         take = 1'b1;
      end else begin
         phase_in = PH_PREAMBLE;
         count_in = 5'd0;
      end

      // store the new bit at its position
      if (take) begin
         for (int k = 0; k < FRAME_BITS; k++) begin
            if (bit_value && count_ff == 5'(k)) begin
               bits_in[k] = 1'b1;
            end
         end
         if (count_ff == 5'(FRAME_BITS - 1)) begin
            done     = 1'b1;
            phase_in = PH_PREAMBLE;
            count_in = 5'd0;
         end else begin
            phase_in = PH_LOW;
            count_in = count_ff + 5'd1;
         end
      end
   end

   // unpack the frame: first received bit most significant in each code word, last in command_bits
   always_comb begin
      frame.done = done;
      for (int k = 0; k < WORD_BITS; k++) begin
         frame.code_high[WORD_BITS-1-k] = bits_in[k];
         frame.code_low[WORD_BITS-1-k]  = bits_in[WORD_BITS+k];
      end
      frame.command_bits = bits_in[FRAME_BITS-1:CODE_BITS];
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREAMBLE;
         count_ff <= 5'd0;
         bits_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

FILE: design/rrcd_slot_cell.sv
// one code store slot: compares the passing probe, deletes on a hit in delete
// mode and forwards the probe with its hit and free markers; depends on rrcd_pkg
module rrcd_slot_cell
   import rrcd_pkg::*;
#(
   parameter int IDX_W = 1,
   parameter int SLOT  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  probe_type            probe_in,
   input  logic [IDX_W-1:0]     hit_idx_in,
   input  logic [IDX_W-1:0]     free_idx_in,
   input  logic                 wr_en,
   input  logic [CODE_BITS-1:0] wr_code,
   output probe_type            probe_out,
   output logic [IDX_W-1:0]     hit_idx_out,
   output logic [IDX_W-1:0]     free_idx_out
);

   logic                 valid_ff;
   logic [CODE_BITS-1:0] code_ff;
   logic                 match;
   probe_type            probe_ff, probe_in_next;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in_next;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in_next;

   assign match = valid_ff && (code_ff == probe_in.code);

   // first hit and first free slot markers
   always_comb begin
      probe_in_next      = probe_in;
      probe_in_next.hit  = probe_in.hit | match;
      probe_in_next.free = probe_in.free | !valid_ff;
      hit_idx_in_next    = probe_in.hit ? hit_idx_in : IDX_W'(SLOT);
      free_idx_in_next   = probe_in.free ? free_idx_in : IDX_W'(SLOT);
   end

   // probe hand-over to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
      hit_idx_ff  <= hit_idx_in_next;
      free_idx_ff <= free_idx_in_next;
   end

   // slot contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end else if (probe_in.live && probe_in.mode == MODE_DELETE && match) begin
         valid_ff <= 1'b0;
      end
      if (wr_en) begin
         code_ff <= wr_code;
      end else if (probe_in.live && probe_in.mode == MODE_DELETE && match) begin
         code_ff <= '0;
      end
   end

   assign probe_out    = probe_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

FILE: design/rf_remote_code_decoder_learner.sv
// top level of the remote code decoder with learning store
// depends on rrcd_pkg, rrcd_if, rrcd_frame_decoder and rrcd_slot_cell
//
// req carries one receiver edge per transfer: the interval since the previous
// edge, the line level after it and the operating mode. rsp returns exactly one
// result item per edge. An edge that does not finish a frame gives an all-zero
// result, registered through the done state and the output register. An edge
// that finishes a 24-bit frame sends the code from the launch register along the
// row of MAX_CODES slot cells, one cell per cycle, which matches, deletes or finds
// a free slot; the result then goes through the done state and output register.
// One item is in work at a time: req.ready is high only while idle.
// The result waits in an output register; while rsp stalls, one finished
// result is held there and the next edge is still taken, its result waiting
// until the register frees up.
// Synchronous reset empties all slots and returns the decoder to preamble
// search; no clearing pass is needed.
module rf_remote_code_decoder_learner
   import rrcd_pkg::*;
#(
   parameter int MAX_CODES = 2
) (
   input  logic     clock,
   input  logic     reset,
   rrcd_req_if.sink   req,
   rrcd_rsp_if.source rsp
);

   localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]   state_ff, state_in;
   frame_type    frame;
   logic         req_xfer, out_free, out_load, learn_wr;
   probe_type    launch_ff;
   rsp_data_type pend_ff, rsp_data_ff;
   rsp_data_type pend_start;
   logic         rsp_valid_ff;
   probe_type    tail;

   probe_type        chain_probe [MAX_CODES+1];
   logic [IDX_W-1:0] chain_hit   [MAX_CODES+1];
   logic [IDX_W-1:0] chain_free  [MAX_CODES+1];

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign out_load  = (state_ff == ST_DONE) && out_free;
   assign tail      = chain_probe[MAX_CODES];

   // frame decoder
   rrcd_frame_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .step        (req_xfer),
      .duration_us (req.duration_us),
      .line_level  (req.line_level),
      .frame       (frame)
   );

   // probe launch into the first cell
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= '0;
      end else begin
         launch_ff.live <= req_xfer && frame.done;
         if (req_xfer) begin
            launch_ff.code <= {frame.code_high, frame.code_low};
            launch_ff.mode <= req.mode;
            launch_ff.hit  <= 1'b0;
            launch_ff.free <= 1'b0;
         end
      end
   end

   assign chain_probe[0] = launch_ff;
   assign chain_hit[0]   = '0;
   assign chain_free[0]  = '0;

   // learn write into the first free slot once the probe has seen every slot
   assign learn_wr = (state_ff == ST_WALK) && tail.live && tail.mode == MODE_LEARN &&
                     tail.free && !tail.hit;

   // row of slot cells
   for (genvar i = 0; i < MAX_CODES; i++) begin : g_cell
      rrcd_slot_cell #(
         .IDX_W (IDX_W),
         .SLOT  (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .probe_in     (chain_probe[i]),
         .hit_idx_in   (chain_hit[i]),
         .free_idx_in  (chain_free[i]),
         .wr_en        (learn_wr && chain_free[MAX_CODES] == IDX_W'(i)),
         .wr_code      (tail.code),
         .probe_out    (chain_probe[i+1]),
         .hit_idx_out  (chain_hit[i+1]),
         .free_idx_out (chain_free[i+1])
      );
   end

   // item sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = frame.done ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (tail.live) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result fields known at the edge transfer
   always_comb begin
      pend_start            = '0;
      pend_start.frame_done = frame.done;
      if (frame.done) begin
         pend_start.code_high    = frame.code_high;
         pend_start.code_low     = frame.code_low;
         pend_start.command_bits = frame.command_bits;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pend_ff <= pend_start;
      end else if (state_ff == ST_WALK && tail.live) begin
         pend_ff.matched       <= tail.mode == MODE_MATCH && tail.hit;
         pend_ff.match_slot    <= tail.mode == MODE_MATCH && tail.hit &&
                                  chain_hit[MAX_CODES][0];
         pend_ff.learn_refused <= tail.mode == MODE_LEARN && !tail.free;
         pend_ff.already_known <= tail.mode == MODE_LEARN && tail.free && tail.hit;
         pend_ff.learned       <= learn_wr;
         pend_ff.deleted       <= tail.mode == MODE_DELETE && tail.hit;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= pend_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.frame_done    = rsp_data_ff.frame_done;
   assign rsp.code_high     = rsp_data_ff.code_high;
   assign rsp.code_low      = rsp_data_ff.code_low;
   assign rsp.command_bits  = rsp_data_ff.command_bits;
   assign rsp.matched       = rsp_data_ff.matched;
   assign rsp.match_slot    = rsp_data_ff.match_slot;
   assign rsp.learned       = rsp_data_ff.learned;
   assign rsp.already_known = rsp_data_ff.already_known;
   assign rsp.learn_refused = rsp_data_ff.learn_refused;
   assign rsp.deleted       = rsp_data_ff.deleted;

   // checks

   // an accepted edge always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != ST_IDLE)
      else $error("edge accepted but sequencer stayed idle");

   // at most one probe walks the row at a time
   logic [MAX_CODES:0] live_vec;
   for (genvar i = 0; i <= MAX_CODES; i++) begin : g_live
      assign live_vec[i] = chain_probe[i].live;
   end
   assert property (@(posedge clock) disable iff (reset) $onehot0(live_vec))
      else $error("more than one probe in the slot row");

   // store outcome flags exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.matched, rsp_data_ff.learned,
                                 rsp_data_ff.already_known, rsp_data_ff.learn_refused,
                                 rsp_data_ff.deleted}))
      else $error("conflicting store outcome flags");

   // no flags without a completed frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.frame_done) |-> rsp_data_ff == '0)
      else $error("non-zero result without a completed frame");

endmodule
